FILE: src/byte_budget_lru_cache_assert.svh
// assertion macros for the byte budget lru cache
// used by the top level; expects i_clk and i_rst_n in scope
`ifndef BYTE_BUDGET_LRU_CACHE_ASSERT_SVH
`define BYTE_BUDGET_LRU_CACHE_ASSERT_SVH
`ifndef SYNTHESIS
`define BBL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
`define BBL_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);
`else
`define BBL_ASSERT(lbl, prop, msg)
`define BBL_NEVER(lbl, cond, msg)
`endif
`endif

FILE: src/bbl_pkg.sv
// shared constants and types for the byte budget lru cache
// no dependencies
package bbl_pkg;
    localparam int ENTRIES   = 16;
    localparam int SIZE_BITS = 25;
    localparam int REC_W     = $clog2(ENTRIES);
    localparam int CNT_W     = $clog2(ENTRIES + 1);
    localparam int KEY_W     = 17;
    localparam int BYTES_W   = 30;
    localparam logic [BYTES_W-1:0] BYTES_MAX    = {BYTES_W{1'b1}};
    localparam logic [BYTES_W-1:0] BUDGET_RESET = 30'd268435456;

    localparam logic [2:0] CMD_GET      = 3'd0;
    localparam logic [2:0] CMD_PUT      = 3'd1;
    localparam logic [2:0] CMD_REMOVE   = 3'd2;
    localparam logic [2:0] CMD_CONTAINS = 3'd3;
    localparam logic [2:0] CMD_CLEAR    = 3'd4;
    localparam logic [2:0] CMD_TRIM     = 3'd5;

    localparam logic [2:0] OP_NONE       = 3'd0;
    localparam logic [2:0] OP_PROMOTE    = 3'd1;
    localparam logic [2:0] OP_DROP_MATCH = 3'd2;
    localparam logic [2:0] OP_DROP_LRU   = 3'd3;
    localparam logic [2:0] OP_CLEAR      = 3'd4;
    localparam logic [2:0] OP_INSERT     = 3'd5;

    typedef struct packed {
        logic [2:0]           op;
        logic [KEY_W-1:0]     key;
        logic [SIZE_BITS-1:0] size;
        logic [REC_W-1:0]     lru;
        logic [REC_W-1:0]     ref_rec;
    } t_cell_ctl;

    typedef struct packed {
        logic                 hit;
        logic [REC_W-1:0]     rec;
        logic [SIZE_BITS-1:0] size;
        logic                 free_seen;
    } t_chain;
endpackage

FILE: src/bbl_if.sv
// transaction channels of the byte budget lru cache
// depends on bbl_pkg
interface bbl_in_if;
    logic                          valid;
    logic                          ready;
    logic [2:0]                    command;
    logic signed [7:0]             latitude;
    logic signed [8:0]             longitude;
    logic [bbl_pkg::SIZE_BITS-1:0] tile_bytes;
    modport source (output valid, command, latitude, longitude, tile_bytes, input ready);
    modport sink   (input valid, command, latitude, longitude, tile_bytes, output ready);
endinterface

interface bbl_out_if;
    logic                        valid;
    logic                        ready;
    logic                        found;
    logic [4:0]                  evicted_now;
    logic [bbl_pkg::BYTES_W-1:0] used_bytes;
    logic [4:0]                  resident_count;
    logic [31:0]                 hit_total;
    logic [31:0]                 miss_total;
    logic [31:0]                 eviction_total;
    modport source (output valid, found, evicted_now, used_bytes, resident_count,
                    hit_total, miss_total, eviction_total, input ready);
    modport sink   (input valid, found, evicted_now, used_bytes, resident_count,
                    hit_total, miss_total, eviction_total, output ready);
endinterface

FILE: src/bbl_cell.sv
// one table slot: key, size, recency rank, and its link in the cell chain
// depends on bbl_pkg
module bbl_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bbl_pkg::t_cell_ctl i_ctl,
    input  bbl_pkg::t_chain    i_chain,
    output bbl_pkg::t_chain    o_chain,
    output logic               o_valid
);
    logic                          r_valid, n_valid;
    logic [bbl_pkg::KEY_W-1:0]     r_key, n_key;
    logic [bbl_pkg::SIZE_BITS-1:0] r_size, n_size;
    logic [bbl_pkg::REC_W-1:0]     r_rec, n_rec;
    logic hit, sel, first_free;

    assign hit        = r_valid && (r_key == i_ctl.key);
    assign sel        = (i_ctl.op == bbl_pkg::OP_DROP_LRU) ?
                        (r_valid && (r_rec == i_ctl.lru)) : hit;
    assign first_free = !r_valid && !i_chain.free_seen;

    assign o_chain.hit       = i_chain.hit | hit;
    assign o_chain.rec       = i_chain.rec | (sel ? r_rec : '0);
    assign o_chain.size      = i_chain.size | (sel ? r_size : '0);
    assign o_chain.free_seen = i_chain.free_seen | !r_valid;
    assign o_valid           = r_valid;

    always_comb begin
        n_valid = r_valid;
        n_key   = r_key;
        n_size  = r_size;
        n_rec   = r_rec;
        unique case (i_ctl.op) inside
            bbl_pkg::OP_PROMOTE: begin
                if (hit) begin
                    n_rec = '0;
                end else if (r_valid && r_rec < i_ctl.ref_rec) begin
                    n_rec = r_rec + 1'b1;
                end
            end
            bbl_pkg::OP_DROP_MATCH, bbl_pkg::OP_DROP_LRU: begin
                if (sel) begin
                    n_valid = 1'b0;
                    n_rec   = '0;
                end else if (r_valid && r_rec > i_ctl.ref_rec) begin
                    n_rec = r_rec - 1'b1;
                end
            end
            bbl_pkg::OP_CLEAR: begin
                n_valid = 1'b0;
                n_rec   = '0;
            end
            bbl_pkg::OP_INSERT: begin
                if (first_free) begin
                    n_valid = 1'b1;
                    n_key   = i_ctl.key;
                    n_size  = i_ctl.size;
                    n_rec   = '0;
                end else if (r_valid) begin
                    n_rec = r_rec + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_rec   <= '0;
        end else begin
            r_valid <= n_valid;
            r_rec   <= n_rec;
        end
        r_key  <= n_key;
        r_size <= n_size;
    end
endmodule

FILE: src/byte_budget_lru_cache.sv
// top level of the byte budget lru cache: sequencer, totals and the cell row
// depends on bbl_pkg, bbl_if, bbl_cell and byte_budget_lru_cache_assert.svh
//
// channel   dir  handshake      payload
// i_item    in   valid/ready    command, latitude, longitude, tile_bytes
// o_result  out  valid/ready    found, evicted_now, used_bytes, resident_count, totals
// i_cfg_*   in   write enable   memory_budget
//
// one cell-row operation per cycle: after acceptance the sequencer runs look, then
// evict for put and trim (one step per eviction, then a final check), insert for put
// and fin, held while o_result is full; the result turns valid as i_item turns ready
// one transaction at a time; the next is taken while a result waits in o_result,
// whose own result then stalls until the waiting one is taken
// synchronous active-low reset clears all slots, totals and sets the budget
module byte_budget_lru_cache (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [bbl_pkg::BYTES_W-1:0] i_cfg_data,
    bbl_in_if.sink                      i_item,
    bbl_out_if.source                   o_result
);
`include "byte_budget_lru_cache_assert.svh"

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LOOK   = 3'd1;
    localparam logic [2:0] S_EVICT  = 3'd2;
    localparam logic [2:0] S_INSERT = 3'd3;
    localparam logic [2:0] S_FIN    = 3'd4;

    logic [2:0]                    r_state, n_state;
    logic [bbl_pkg::BYTES_W-1:0]   r_budget;
    logic [2:0]                    r_cmd;
    logic [bbl_pkg::KEY_W-1:0]     r_key;
    logic [bbl_pkg::SIZE_BITS-1:0] r_size;
    logic                          r_found, n_found;
    logic [bbl_pkg::CNT_W-1:0]     r_evicted, n_evicted;
    logic [bbl_pkg::BYTES_W-1:0]   r_bytes, n_bytes;
    logic [bbl_pkg::CNT_W-1:0]     r_slots, n_slots;
    logic [31:0]                   r_hits, n_hits, r_misses, n_misses, r_evicts, n_evicts;
    logic                          r_out_valid;

    bbl_pkg::t_cell_ctl            ctl;
    bbl_pkg::t_chain               w_chain [bbl_pkg::ENTRIES+1];
    logic [bbl_pkg::ENTRIES-1:0]   w_valid;

    logic [bbl_pkg::BYTES_W-1:0]   sel_bytes, bytes_sub;
    logic [bbl_pkg::BYTES_W:0]     need, ins_sum;
    logic                          over, full, is_put;

    assign w_chain[0] = '0;
    for (genvar g = 0; g < bbl_pkg::ENTRIES; g++) begin : g_cell
        bbl_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl),
            .i_chain (w_chain[g]),
            .o_chain (w_chain[g+1]),
            .o_valid (w_valid[g])
        );
    end

    assign is_put    = (r_cmd == bbl_pkg::CMD_PUT);
    assign sel_bytes = bbl_pkg::BYTES_W'(w_chain[bbl_pkg::ENTRIES].size);
    assign bytes_sub = (r_bytes >= sel_bytes) ? r_bytes - sel_bytes : '0;
    // trim evicts against the budget alone
    assign need      = {1'b0, r_bytes} + (is_put ? (bbl_pkg::BYTES_W+1)'(r_size) : '0);
    assign over      = need > {1'b0, r_budget};
    assign full      = (r_slots == bbl_pkg::CNT_W'(bbl_pkg::ENTRIES));
    assign ins_sum   = {1'b0, r_bytes} + (bbl_pkg::BYTES_W+1)'(r_size);

    assign i_item.ready = (r_state == S_IDLE);

    always_comb begin
        n_state   = r_state;
        n_found   = r_found;
        n_evicted = r_evicted;
        n_bytes   = r_bytes;
        n_slots   = r_slots;
        n_hits    = r_hits;
        n_misses  = r_misses;
        n_evicts  = r_evicts;
        ctl.op      = bbl_pkg::OP_NONE;
        ctl.key     = r_key;
        ctl.size    = r_size;
        ctl.lru     = bbl_pkg::REC_W'(r_slots - 1'b1);
        ctl.ref_rec = w_chain[bbl_pkg::ENTRIES].rec;
        unique case (r_state)
            S_IDLE: begin
                if (i_item.valid) begin
                    n_state   = S_LOOK;
                    n_found   = 1'b0;
                    n_evicted = '0;
                end
            end
            S_LOOK: begin
                n_state = S_FIN;
                case (r_cmd) inside
                    bbl_pkg::CMD_GET: begin
                        if (w_chain[bbl_pkg::ENTRIES].hit) begin
                            ctl.op  = bbl_pkg::OP_PROMOTE;
                            n_found = 1'b1;
                            n_hits  = r_hits + 1'b1;
                        end else begin
                            n_misses = r_misses + 1'b1;
                        end
                    end
                    bbl_pkg::CMD_PUT, bbl_pkg::CMD_REMOVE: begin
                        if (w_chain[bbl_pkg::ENTRIES].hit) begin
                            ctl.op  = bbl_pkg::OP_DROP_MATCH;
                            n_found = 1'b1;
                            n_bytes = bytes_sub;
                            n_slots = r_slots - 1'b1;
                        end
                        if (is_put) begin
                            n_state = S_EVICT;
                        end
                    end
                    bbl_pkg::CMD_CONTAINS: begin
                        n_found = w_chain[bbl_pkg::ENTRIES].hit;
                    end
                    bbl_pkg::CMD_CLEAR: begin
                        ctl.op  = bbl_pkg::OP_CLEAR;
                        n_bytes = '0;
                        n_slots = '0;
                    end
                    bbl_pkg::CMD_TRIM: begin
                        n_state = S_EVICT;
                    end
                    default: begin
                    end
                endcase
            end
            S_EVICT: begin
                // a full table on put also frees one slot
                if (r_slots != '0 && (over || (is_put && full))) begin
                    ctl.op    = bbl_pkg::OP_DROP_LRU;
                    n_bytes   = bytes_sub;
                    n_slots   = r_slots - 1'b1;
                    n_evicted = r_evicted + 1'b1;
                    n_evicts  = r_evicts + 1'b1;
                end else begin
                    n_state = is_put ? S_INSERT : S_FIN;
                end
            end
            S_INSERT: begin
                ctl.op  = bbl_pkg::OP_INSERT;
                n_slots = r_slots + 1'b1;
                n_bytes = ins_sum[bbl_pkg::BYTES_W] ? bbl_pkg::BYTES_MAX :
                          ins_sum[bbl_pkg::BYTES_W-1:0];
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_out_valid || o_result.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_budget    <= bbl_pkg::BUDGET_RESET;
            r_found     <= 1'b0;
            r_evicted   <= '0;
            r_bytes     <= '0;
            r_slots     <= '0;
            r_hits      <= '0;
            r_misses    <= '0;
            r_evicts    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_found   <= n_found;
            r_evicted <= n_evicted;
            r_bytes   <= n_bytes;
            r_slots   <= n_slots;
            r_hits    <= n_hits;
            r_misses  <= n_misses;
            r_evicts  <= n_evicts;
            if (i_cfg_we) begin
                r_budget <= i_cfg_data;
            end
            if (r_state == S_FIN && (!r_out_valid || o_result.ready)) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_cmd  <= i_item.command;
            r_key  <= {i_item.latitude, i_item.longitude};
            r_size <= i_item.tile_bytes;
        end
        if (r_state == S_FIN && (!r_out_valid || o_result.ready)) begin
            o_result.found          <= r_found;
            o_result.evicted_now    <= 5'(r_evicted);
            o_result.used_bytes     <= r_bytes;
            o_result.resident_count <= 5'(r_slots);
            o_result.hit_total      <= r_hits;
            o_result.miss_total     <= r_misses;
            o_result.eviction_total <= r_evicts;
        end
    end

    assign o_result.valid = r_out_valid;

    `BBL_ASSERT(a_slots_match, $countones(w_valid) == 32'(r_slots), "slot count drift")
    `BBL_NEVER(a_slots_bound, r_slots > bbl_pkg::CNT_W'(bbl_pkg::ENTRIES), "slot count overflow")
    `BBL_ASSERT(a_accept_look, (i_item.valid && i_item.ready) |=> (r_state == S_LOOK), "no lookup")
endmodule
